>>> rtl/core/fwrt_pkg.sv
// fwrt_pkg: shared types, codes and the microcode ROM of the firewall rule table.
// Used by fwrt_rule_store and firewall_rule_table_core. No dependencies.
package fwrt_pkg;

   localparam int RULE_SLOTS = 32;
   localparam int SLOT_W     = 5;   // index of one rule slot
   localparam int COUNT_W    = 6;   // rule count, 0 .. RULE_SLOTS

   // request kinds
   localparam logic [1:0] KIND_ADD    = 2'd0;
   localparam logic [1:0] KIND_CHECK  = 2'd1;
   localparam logic [1:0] KIND_DELETE = 2'd2;

   // response status codes
   localparam logic [2:0] STATUS_ADDED    = 3'd0;
   localparam logic [2:0] STATUS_FULL     = 3'd1;
   localparam logic [2:0] STATUS_INVALID  = 3'd2;
   localparam logic [2:0] STATUS_ACCEPTED = 3'd3;
   localparam logic [2:0] STATUS_REJECTED = 3'd4;
   localparam logic [2:0] STATUS_DELETED  = 3'd5;
   localparam logic [2:0] STATUS_NOTFOUND = 3'd6;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] addr_first;
      logic [31:0] addr_last;
      logic [15:0] port_first;
      logic [15:0] port_last;
   } req_type;

   typedef struct packed {
      logic [2:0]        status;
      logic [SLOT_W-1:0] rule_slot;
   } rsp_type;

   typedef struct packed {
      logic [31:0] addr_lo;
      logic [31:0] addr_hi;
      logic [15:0] port_lo;
      logic [15:0] port_hi;
   } rule_type;

   typedef struct packed {
      logic              wr_en;
      logic [SLOT_W-1:0] wr_addr;
      logic [SLOT_W-1:0] rd_addr;
   } mem_ctrl_type;

   // microprogram steps
   typedef enum logic [3:0] {
      STEP_WAIT,
      STEP_DISP0,
      STEP_DISP1,
      STEP_ADD,
      STEP_CHK0,
      STEP_CHK1,
      STEP_DEL0,
      STEP_DEL1,
      STEP_SH0,
      STEP_SH1,
      STEP_DEL_DONE,
      STEP_R_INVALID,
      STEP_R_FULL,
      STEP_R_REJECT,
      STEP_R_ACCEPT,
      STEP_R_NOTFOUND
   } step_type;

   typedef enum logic [3:0] {
      COND_NEVER,
      COND_NOT_START,
      COND_IS_CHECK,
      COND_INVALID,
      COND_IS_DELETE,
      COND_FULL,
      COND_SCAN_END,
      COND_HIT,
      COND_MATCH
   } cond_type;

   typedef enum logic [1:0] {
      SLOT_ZERO,
      SLOT_SCAN,
      SLOT_TOTAL
   } slot_sel_type;

   // one control word; idx_inc only acts when neither branch is taken
   typedef struct packed {
      cond_type     br1_cond;
      step_type     br1_step;
      cond_type     br2_cond;
      step_type     br2_step;
      step_type     next_step;
      logic         load;
      logic         idx_clr;
      logic         idx_inc;
      logic         slot_cap;
      logic         add_write;
      logic         shift_write;
      logic         total_inc;
      logic         total_dec;
      logic         respond;
      logic [2:0]   status;
      slot_sel_type slot_sel;
   } ctrl_word_type;

   function automatic ctrl_word_type ucode_rom(input step_type pc);
      ctrl_word_type w;
      w           = '0;
      w.br1_cond  = COND_NEVER;
      w.br1_step  = STEP_WAIT;
      w.br2_cond  = COND_NEVER;
      w.br2_step  = STEP_WAIT;
      w.next_step = STEP_WAIT;
      w.slot_sel  = SLOT_ZERO;
      case (pc)
         STEP_WAIT: begin
            w.br1_cond  = COND_NOT_START;
            w.br1_step  = STEP_WAIT;
            w.load      = 1'b1;
            w.idx_clr   = 1'b1;
            w.next_step = STEP_DISP0;
         end
         STEP_DISP0: begin
            w.br1_cond  = COND_IS_CHECK;
            w.br1_step  = STEP_CHK0;
            w.br2_cond  = COND_INVALID;
            w.br2_step  = STEP_R_INVALID;
            w.next_step = STEP_DISP1;
         end
         STEP_DISP1: begin
            w.br1_cond  = COND_IS_DELETE;
            w.br1_step  = STEP_DEL0;
            w.br2_cond  = COND_FULL;
            w.br2_step  = STEP_R_FULL;
            w.next_step = STEP_ADD;
         end
         STEP_ADD: begin
            w.add_write = 1'b1;
            w.total_inc = 1'b1;
            w.respond   = 1'b1;
            w.status    = STATUS_ADDED;
            w.slot_sel  = SLOT_TOTAL;
         end
         STEP_CHK0: begin
            w.br1_cond  = COND_SCAN_END;
            w.br1_step  = STEP_R_REJECT;
            w.idx_inc   = 1'b1;
            w.next_step = STEP_CHK1;
         end
         STEP_CHK1: begin
            w.br1_cond  = COND_HIT;
            w.br1_step  = STEP_R_ACCEPT;
            w.br2_cond  = COND_SCAN_END;
            w.br2_step  = STEP_R_REJECT;
            w.idx_inc   = 1'b1;
            w.slot_cap  = 1'b1;
            w.next_step = STEP_CHK1;
         end
         STEP_DEL0: begin
            w.br1_cond  = COND_SCAN_END;
            w.br1_step  = STEP_R_NOTFOUND;
            w.idx_inc   = 1'b1;
            w.next_step = STEP_DEL1;
         end
         STEP_DEL1: begin
            w.br1_cond  = COND_MATCH;
            w.br1_step  = STEP_SH0;
            w.br2_cond  = COND_SCAN_END;
            w.br2_step  = STEP_R_NOTFOUND;
            w.idx_inc   = 1'b1;
            w.slot_cap  = 1'b1;
            w.next_step = STEP_DEL1;
         end
         STEP_SH0: begin
            w.br1_cond  = COND_SCAN_END;
            w.br1_step  = STEP_DEL_DONE;
            w.idx_inc   = 1'b1;
            w.next_step = STEP_SH1;
         end
         STEP_SH1: begin
            w.shift_write = 1'b1;
            w.br1_cond    = COND_SCAN_END;
            w.br1_step    = STEP_DEL_DONE;
            w.idx_inc     = 1'b1;
            w.next_step   = STEP_SH1;
         end
         STEP_DEL_DONE: begin
            w.total_dec = 1'b1;
            w.respond   = 1'b1;
            w.status    = STATUS_DELETED;
            w.slot_sel  = SLOT_SCAN;
         end
         STEP_R_INVALID: begin
            w.respond = 1'b1;
            w.status  = STATUS_INVALID;
         end
         STEP_R_FULL: begin
            w.respond = 1'b1;
            w.status  = STATUS_FULL;
         end
         STEP_R_REJECT: begin
            w.respond = 1'b1;
            w.status  = STATUS_REJECTED;
         end
         STEP_R_ACCEPT: begin
            w.respond  = 1'b1;
            w.status   = STATUS_ACCEPTED;
            w.slot_sel = SLOT_SCAN;
         end
         STEP_R_NOTFOUND: begin
            w.respond = 1'b1;
            w.status  = STATUS_NOTFOUND;
         end
         default: begin
            w.next_step = STEP_WAIT;
         end
      endcase
      return w;
   endfunction

endpackage

>>> rtl/core/fwrt_rule_store.sv
// fwrt_rule_store: rule memory, one write and one registered read per cycle.
// Depends on fwrt_pkg.
module fwrt_rule_store (
   input  logic                   clock,
   input  fwrt_pkg::mem_ctrl_type mem_ctrl,
   input  fwrt_pkg::rule_type     wr_data,
   output fwrt_pkg::rule_type     rd_data
);

   fwrt_pkg::rule_type rules_mem [fwrt_pkg::RULE_SLOTS];
   fwrt_pkg::rule_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_ctrl.wr_en) begin
         rules_mem[mem_ctrl.wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= rules_mem[mem_ctrl.rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/firewall_rule_table_core.sv
// firewall_rule_table_core: ordered first-match firewall rule table, microcoded.
// Depends on fwrt_pkg and fwrt_rule_store.
//
// Use:
//   Request: drive req_word and raise start; the word is taken on the clock
//   edge where start is high and busy is low. busy stays high until the
//   response has been issued, so one request is in flight at a time and a new
//   word can be taken on the edge that ends the strobe cycle.
//   Response: rsp_word is valid for exactly one cycle while rsp_strobe is
//   high; the receiver must take it then, it cannot hold the block off.
//   Invalid, add and full requests are answered after the dispatch steps; a
//   check scans the stored rules in slot order up to the first hit or the
//   end, and a delete scans for the first exact match, then moves every
//   later rule to the next lower slot.
//   The scan and the shift both run at one rule per cycle through the single
//   read port of the rule memory; the shift writes slot j while reading j+2.
//   Control comes from a 16-step microprogram (fwrt_pkg::ucode_rom): each
//   step gives two conditional branches, a default next step and the
//   datapath strobes.
//   Reset clears the step counter, the rule count and the response strobe;
//   the rule memory is not cleared, slots at or beyond the count are never
//   read for a result.
module firewall_rule_table_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  fwrt_pkg::req_type req_word,
   output logic              rsp_strobe,
   output fwrt_pkg::rsp_type rsp_word
);

   // sequencer
   fwrt_pkg::step_type      step_ff, step_in;
   fwrt_pkg::ctrl_word_type ctrl;
   logic                    taken1, taken2;

   // datapath
   fwrt_pkg::req_type                 req_ff;
   logic [fwrt_pkg::COUNT_W-1:0]      idx_ff, idx_in;
   logic [fwrt_pkg::COUNT_W-1:0]      total_ff, total_in;
   logic [fwrt_pkg::COUNT_W-1:0]      idx_less1, idx_less2;
   logic [fwrt_pkg::SLOT_W-1:0]       slot_ff, slot_in;
   logic                              rsp_strobe_ff, rsp_strobe_in;
   fwrt_pkg::rsp_type                 rsp_ff, rsp_in;

   fwrt_pkg::mem_ctrl_type mem_ctrl;
   fwrt_pkg::rule_type     wr_data, rd_data, req_rule;

   logic rule_ok, hit, match, scan_end, full;

   fwrt_rule_store u_store (
      .clock    (clock),
      .mem_ctrl (mem_ctrl),
      .wr_data  (wr_data),
      .rd_data  (rd_data)
   );

   // condition flags
   assign req_rule.addr_lo = req_ff.addr_first;
   assign req_rule.addr_hi = req_ff.addr_last;
   assign req_rule.port_lo = req_ff.port_first;
   assign req_rule.port_hi = req_ff.port_last;

   assign rule_ok  = (req_ff.addr_first <= req_ff.addr_last) &&
                     (req_ff.port_first <= req_ff.port_last);
   // inclusive range test of the stored rule against the queried address and port
   assign hit      = (rd_data.addr_lo <= req_ff.addr_first) &&
                     (req_ff.addr_first <= rd_data.addr_hi) &&
                     (rd_data.port_lo <= req_ff.port_first) &&
                     (req_ff.port_first <= rd_data.port_hi);
   assign match    = (rd_data == req_rule);
   assign scan_end = (idx_ff == total_ff);
   assign full     = (total_ff == fwrt_pkg::COUNT_W'(fwrt_pkg::RULE_SLOTS));

   assign idx_less1 = idx_ff - fwrt_pkg::COUNT_W'(1);
   assign idx_less2 = idx_ff - fwrt_pkg::COUNT_W'(2);

   function automatic logic cond_eval(input fwrt_pkg::cond_type c, input logic start_now,
                                      input logic [1:0] kind, input logic ok,
                                      input logic is_full, input logic at_end,
                                      input logic is_hit, input logic is_match);
      logic r;
      case (c)
         fwrt_pkg::COND_NEVER:     r = 1'b0;
         fwrt_pkg::COND_NOT_START: r = !start_now;
         fwrt_pkg::COND_IS_CHECK:  r = (kind == fwrt_pkg::KIND_CHECK);
         // a kind other than add or delete (check is dispatched first), or a rule with reversed bounds
         fwrt_pkg::COND_INVALID:   r = (kind != fwrt_pkg::KIND_ADD) &&
                                       (kind != fwrt_pkg::KIND_DELETE) || !ok;
         fwrt_pkg::COND_IS_DELETE: r = (kind == fwrt_pkg::KIND_DELETE);
         fwrt_pkg::COND_FULL:      r = is_full;
         fwrt_pkg::COND_SCAN_END:  r = at_end;
         fwrt_pkg::COND_HIT:       r = is_hit;
         fwrt_pkg::COND_MATCH:     r = is_match;
         default:                  r = 1'b0;
      endcase
      return r;
   endfunction

   // next step and datapath controls
   always_comb begin
      ctrl   = fwrt_pkg::ucode_rom(step_ff);
      taken1 = cond_eval(ctrl.br1_cond, start, req_ff.kind, rule_ok, full,
                         scan_end, hit, match);
      taken2 = cond_eval(ctrl.br2_cond, start, req_ff.kind, rule_ok, full,
                         scan_end, hit, match);

      if (taken1) begin
         step_in = ctrl.br1_step;
      end else if (taken2) begin
         step_in = ctrl.br2_step;
      end else begin
         step_in = ctrl.next_step;
      end

      idx_in = idx_ff;
      if (ctrl.idx_clr) begin
         idx_in = '0;
      end else if (ctrl.idx_inc && !taken1 && !taken2) begin
         idx_in = idx_ff + fwrt_pkg::COUNT_W'(1);
      end

      total_in = total_ff;
      if (ctrl.total_inc) begin
         total_in = total_ff + fwrt_pkg::COUNT_W'(1);
      end else if (ctrl.total_dec) begin
         total_in = total_ff - fwrt_pkg::COUNT_W'(1);
      end

      // during a scan the registered read data belongs to slot idx - 1
      slot_in = ctrl.slot_cap ? idx_less1[fwrt_pkg::SLOT_W-1:0] : slot_ff;

      // memory: append at the count, or move a rule to the next lower slot
      mem_ctrl.rd_addr = idx_ff[fwrt_pkg::SLOT_W-1:0];
      mem_ctrl.wr_en   = ctrl.add_write || ctrl.shift_write;
      mem_ctrl.wr_addr = ctrl.add_write ? total_ff[fwrt_pkg::SLOT_W-1:0]
                                        : idx_less2[fwrt_pkg::SLOT_W-1:0];
      wr_data          = ctrl.add_write ? req_rule : rd_data;

      rsp_strobe_in   = ctrl.respond;
      rsp_in.status   = ctrl.status;
      case (ctrl.slot_sel)
         fwrt_pkg::SLOT_SCAN:  rsp_in.rule_slot = slot_ff;
         fwrt_pkg::SLOT_TOTAL: rsp_in.rule_slot = total_ff[fwrt_pkg::SLOT_W-1:0];
         default:              rsp_in.rule_slot = '0;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff       <= fwrt_pkg::STEP_WAIT;
         total_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         step_ff       <= step_in;
         total_ff      <= total_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         req_ff <= req_word;
      end
      idx_ff  <= idx_in;
      slot_ff <= slot_in;
      rsp_ff  <= rsp_in;
   end

   assign busy       = (step_ff != fwrt_pkg::STEP_WAIT);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_ff;

endmodule
